@@ rtl/efp_pkg.sv @@
// Shared types and constants for the escape-time fractal pixel block.
// No dependencies; compiled first.
package efp_pkg;

    // Operand width of the shared signed multiplier (one plane coordinate)
    localparam int MUL_W = 32;

    // Width of one colour channel and of the result count field
    localparam int CHAN_W  = 8;
    localparam int COUNT_W = 16;

    typedef logic [CHAN_W-1:0] t_chan;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_X_ORIGIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_ORIGIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_STEP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_JULIA     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_C_REAL    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_C_IMAG    = 3'd7;

    // Gradient stops, red / green / blue
    localparam t_chan PALETTE [4][3] = '{
        '{8'd100, 8'd0,   8'd100},
        '{8'd0,   8'd0,   8'd255},
        '{8'd0,   8'd255, 8'd0  },
        '{8'd255, 8'd0,   8'd0  }
    };

endpackage

@@ rtl/efp_pixel_if.sv @@
// Pixel coordinate channel: valid/ready handshake with column and row.
// Depends on nothing.
interface efp_pixel_if #(
    parameter int IDX_W = 12
);
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] column;
    logic [IDX_W-1:0] row;

    modport source (output valid, output column, output row, input ready);
    modport sink   (input valid, input column, input row, output ready);
endinterface

@@ rtl/efp_result_if.sv @@
// Result channel: valid/ready handshake with iteration count and colour.
// Depends on efp_pkg for field widths.
interface efp_result_if;
    import efp_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] iteration_count;
    t_chan              red;
    t_chan              green;
    t_chan              blue;

    modport source (output valid, output iteration_count, output red, output green,
                    output blue, input ready);
    modport sink   (input valid, input iteration_count, input red, input green,
                    input blue, output ready);
endinterface

@@ rtl/escape_time_fractal_pixel_top.sv @@
// Escape-time fractal pixel: the point is mapped in states MX, MY and PT, and each
// iteration runs XX, YY, XY and UP on the shared multiplier; at the limit the colour
// is black, else it is found on the divider (D = min(COUNT_BITS,16) + 8 bits wide).
// One pixel is in work at a time; the next is taken the cycle after its result loads.
// Reset (synchronous, active low) idles the sequencer, drops the result and sets the
// registers to their defaults: limit 256, Mandelbrot mode, origins, steps and c zero.
module escape_time_fractal_pixel_top
    import efp_pkg::*;
#(
    parameter int INDEX_BITS    = 12,
    parameter int COUNT_BITS    = 16,
    parameter int FRACTION_BITS = 26
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    efp_pixel_if.sink            i_pixel,
    efp_result_if.source         o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [MUL_W-1:0]     i_cfg_data
);

    localparam int LIMIT_W = (COUNT_BITS < COUNT_W) ? COUNT_BITS : COUNT_W;
    localparam int DVD_W   = LIMIT_W + CHAN_W;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(256);
    localparam logic [63:0] ESC_LIM = 64'd4 << FRACTION_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_MX, S_MY, S_PT, S_XX, S_YY, S_XY, S_UP,
        S_IDX, S_IDXW, S_CMUL, S_CDIV, S_CDIVW, S_DONE
    } t_state;

    // Sign-extend a coordinate to product width
    function automatic logic signed [63:0] sx(input logic signed [MUL_W-1:0] v);
        return {{(64 - MUL_W){v[MUL_W-1]}}, v};
    endfunction

    // Clamp to the signed 32-bit coordinate range
    function automatic logic signed [MUL_W-1:0] sat(input logic signed [63:0] v);
        if (v[63:MUL_W-1] == '0 || v[63:MUL_W-1] == '1)
            return v[MUL_W-1:0];
        else if (v[63])
            return {1'b1, {(MUL_W-1){1'b0}}};
        else
            return {1'b0, {(MUL_W-1){1'b1}}};
    endfunction

    // Configuration registers
    logic signed [MUL_W-1:0] r_x_origin, r_y_origin, r_x_step, r_y_step;
    logic signed [MUL_W-1:0] r_c_real, r_c_imag;
    logic [LIMIT_W-1:0]      r_limit;
    logic                    r_julia;

    // Working state
    t_state                  r_state;
    logic [INDEX_BITS-1:0]   r_col, r_row;
    logic signed [MUL_W-1:0] r_x, r_y, r_cr, r_ci;
    logic signed [63:0]      r_xx;
    logic [LIMIT_W-1:0]      r_count;
    logic [1:0]              r_idx;
    logic [LIMIT_W-1:0]      r_rem;
    logic [1:0]              r_ch;
    t_chan                   r_red, r_green, r_blue;

    // Result register
    logic                    r_ovalid;
    logic [COUNT_W-1:0]      r_ocount;
    t_chan                   r_ored, r_ogreen, r_oblue;

    // Shared unit connections
    logic signed [MUL_W-1:0] n_mul_a, n_mul_b;
    logic signed [63:0]      w_prod;
    logic                    n_div_start;
    logic [DVD_W-1:0]        n_dividend;
    logic                    w_div_done;
    logic [DVD_W-1:0]        w_quot;
    logic [LIMIT_W-1:0]      w_drem;

    // Datapath next values
    logic signed [63:0]      n_xdiff, n_xsh, n_ysh;
    logic [63:0]             n_mag;
    logic signed [MUL_W-1:0] n_px, n_py, n_xnew, n_ynew;
    logic                    n_escape;
    t_chan                   n_left, n_right, n_absdiff, n_chan;
    logic                    n_neg;
    logic                    n_out_free;

    efp_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (n_mul_a),
        .i_b    (n_mul_b),
        .o_prod (w_prod)
    );

    efp_div #(
        .DVD_W (DVD_W),
        .DVS_W (LIMIT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_div_start),
        .i_dividend (n_dividend),
        .i_divisor  (r_limit),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_drem)
    );

    // Route operands to the shared multiplier by step
    always_comb begin
        case (r_state)
            S_MX: begin
                n_mul_a = signed'(MUL_W'(r_col));
                n_mul_b = r_x_step;
            end
            S_MY: begin
                n_mul_a = signed'(MUL_W'(r_row));
                n_mul_b = r_y_step;
            end
            S_XX: begin
                n_mul_a = r_x;
                n_mul_b = r_x;
            end
            S_YY: begin
                n_mul_a = r_y;
                n_mul_b = r_y;
            end
            S_XY: begin
                n_mul_a = r_x;
                n_mul_b = r_y;
            end
            S_CMUL: begin
                n_mul_a = signed'(MUL_W'(n_absdiff));
                n_mul_b = signed'(MUL_W'(r_rem));
            end
            default: begin
                n_mul_a = '0;
                n_mul_b = '0;
            end
        endcase
    end

    // Divider start and dividend: 3*count first, then |diff|*rem per channel
    always_comb begin
        n_div_start = (r_state == S_IDX) || (r_state == S_CDIV);
        if (r_state == S_IDX)
            n_dividend = DVD_W'({r_count, 1'b0}) + DVD_W'(r_count);
        else
            n_dividend = w_prod[DVD_W-1:0];
    end

    // Point mapping, escape test and the next iterate
    always_comb begin
        n_px     = sat(sx(r_x_origin) + w_prod);
        n_py     = sat(sx(r_y_origin) + w_prod);
        n_mag    = (64'(r_xx) + 64'(w_prod)) >> FRACTION_BITS;
        n_escape = (n_mag >= ESC_LIM);
        n_xdiff  = r_xx - w_prod;
        n_xsh    = n_xdiff >>> FRACTION_BITS;
        n_xnew   = sat(n_xsh + sx(r_cr));
        n_ysh    = w_prod >>> (FRACTION_BITS - 1);
        n_ynew   = sat(n_ysh + sx(r_ci));
    end

    // Blend one channel between two gradient stops
    always_comb begin
        n_left    = PALETTE[r_idx][r_ch];
        n_right   = PALETTE[2'(r_idx + 2'd1)][r_ch];
        n_neg     = (n_right < n_left);
        n_absdiff = n_neg ? (n_left - n_right) : (n_right - n_left);
        n_chan    = n_neg ? (n_left - w_quot[CHAN_W-1:0]) : (n_left + w_quot[CHAN_W-1:0]);
        n_out_free = !r_ovalid || o_result.ready;
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_origin <= '0;
            r_y_origin <= '0;
            r_x_step   <= '0;
            r_y_step   <= '0;
            r_limit    <= LIMIT_RST;
            r_julia    <= 1'b0;
            r_c_real   <= '0;
            r_c_imag   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_X_ORIGIN: r_x_origin <= i_cfg_data;
                CFG_Y_ORIGIN: r_y_origin <= i_cfg_data;
                CFG_X_STEP:   r_x_step   <= i_cfg_data;
                CFG_Y_STEP:   r_y_step   <= i_cfg_data;
                CFG_LIMIT:    r_limit    <= i_cfg_data[LIMIT_W-1:0];
                CFG_JULIA:    r_julia    <= i_cfg_data[0];
                CFG_C_REAL:   r_c_real   <= i_cfg_data;
                CFG_C_IMAG:   r_c_imag   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer with its registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            // Drop a taken result unless a new one loads in its place
            if (r_ovalid && o_result.ready && (r_state != S_DONE))
                r_ovalid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (i_pixel.valid) begin
                        r_col   <= i_pixel.column;
                        r_row   <= i_pixel.row;
                        r_state <= S_MX;
                    end
                end
                S_MX: begin
                    r_state <= S_MY;
                end
                S_MY: begin
                    r_x     <= n_px;
                    r_state <= S_PT;
                end
                S_PT: begin
                    r_y     <= n_py;
                    r_cr    <= r_julia ? r_c_real : r_x;
                    r_ci    <= r_julia ? r_c_imag : n_py;
                    r_count <= '0;
                    r_state <= S_XX;
                end
                S_XX: begin
                    if (r_count >= r_limit) begin
                        r_red   <= '0;
                        r_green <= '0;
                        r_blue  <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_YY;
                    end
                end
                S_YY: begin
                    r_xx    <= w_prod;
                    r_state <= S_XY;
                end
                S_XY: begin
                    if (n_escape) begin
                        r_state <= S_IDX;
                    end else begin
                        r_x     <= n_xnew;
                        r_state <= S_UP;
                    end
                end
                S_UP: begin
                    r_y     <= n_ynew;
                    r_count <= r_count + 1'b1;
                    r_state <= S_XX;
                end
                S_IDX: begin
                    r_state <= S_IDXW;
                end
                S_IDXW: begin
                    if (w_div_done) begin
                        r_idx   <= (w_quot > DVD_W'(2)) ? 2'd2 : w_quot[1:0];
                        r_rem   <= w_drem;
                        r_ch    <= 2'd0;
                        r_state <= S_CMUL;
                    end
                end
                S_CMUL: begin
                    r_state <= S_CDIV;
                end
                S_CDIV: begin
                    r_state <= S_CDIVW;
                end
                S_CDIVW: begin
                    if (w_div_done) begin
                        case (r_ch)
                            2'd0:    r_red   <= n_chan;
                            2'd1:    r_green <= n_chan;
                            default: r_blue  <= n_chan;
                        endcase
                        if (r_ch == 2'd2) begin
                            r_state <= S_DONE;
                        end else begin
                            r_ch    <= r_ch + 2'd1;
                            r_state <= S_CMUL;
                        end
                    end
                end
                S_DONE: begin
                    if (n_out_free) begin
                        r_ovalid <= 1'b1;
                        r_ocount <= COUNT_W'(r_count);
                        r_ored   <= r_red;
                        r_ogreen <= r_green;
                        r_oblue  <= r_blue;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_pixel.ready            = (r_state == S_IDLE);
    assign o_result.valid           = r_ovalid;
    assign o_result.iteration_count = r_ocount;
    assign o_result.red             = r_ored;
    assign o_result.green           = r_ogreen;
    assign o_result.blue            = r_oblue;

endmodule

@@ rtl/efp_mul.sv @@
// Shared signed multiplier with a registered product.
// Depends on efp_pkg for the operand width.
module efp_mul
    import efp_pkg::*;
(
    input  logic                      i_clk,
    input  logic signed [MUL_W-1:0]   i_a,
    input  logic signed [MUL_W-1:0]   i_b,
    output logic signed [2*MUL_W-1:0] o_prod
);

    logic signed [2*MUL_W-1:0] r_prod;

    // Register the full-width product
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

@@ rtl/efp_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on efp_pkg only through the common import convention.
module efp_div
    import efp_pkg::*;
#(
    parameter int DVD_W = 24,
    parameter int DVS_W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quot,
    output logic [DVS_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(DVD_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_quot;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   n_shift;
    logic [DVS_W:0]   n_diff;
    logic             n_ge;

    // Shift in the next dividend bit and trial-subtract the divisor
    always_comb begin
        n_shift = {r_rem, r_quot[DVD_W-1]};
        n_diff  = n_shift - {1'b0, r_dvs};
        n_ge    = (n_shift >= {1'b0, r_dvs});
    end

    // Step the quotient and partial remainder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= '0;
                r_quot <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem  <= n_ge ? n_diff[DVS_W-1:0] : n_shift[DVS_W-1:0];
                r_quot <= {r_quot[DVD_W-2:0], n_ge};
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_done <= 1'b0;
                    r_cnt  <= r_cnt + 1'b1;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule
